[src/iso_week_date_calculator_defines.svh]
// ----------------------------------------------------------------------------
// iso week date calculator assertion macros
// concurrent assertion forms, clocked on clk_i, held off in reset
// ----------------------------------------------------------------------------
`ifndef ISO_WEEK_DATE_CALCULATOR_DEFINES_SVH
`define ISO_WEEK_DATE_CALCULATOR_DEFINES_SVH

// antecedent in this cycle implies consequent in the same cycle
`define IWD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iwd check failed");

// antecedent implies consequent a fixed number of cycles later
`define IWD_ASSERT_LATER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("iwd latency check failed");

`endif

[src/iwd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iwd_pkg
// constants for the iso week date pipeline: ordinal offsets and reciprocals
// ----------------------------------------------------------------------------
package iwd_pkg;

  localparam int YearW = 14;
  localparam int MonthW = 4;
  localparam int DayW = 5;
  localparam int WeekdayW = 3;
  localparam int DoyW = 9;
  localparam int WeekW = 6;
  localparam int OrdW = 10;  // signed ordinal, zero based

  // ord = day + offset(month), zero based; jan/feb and month 0 relative to
  // the base year, later months include the march-onward sum plus 58
  localparam logic signed [OrdW-1:0] OrdOffset [16] = '{
    -10'sd32, -10'sd1, 10'sd30, 10'sd58, 10'sd89, 10'sd119, 10'sd150, 10'sd180,
    10'sd211, 10'sd242, 10'sd272, 10'sd303, 10'sd333, 10'sd364, 10'sd395, 10'sd425
  };

  // floor(x / 100) = (x * Recip100) >> Recip100Sh for x < 2^14
  localparam logic [13:0] Recip100 = 14'd10486;
  localparam int Recip100Sh = 20;
  localparam logic [6:0] Hundred = 7'd100;

  // floor(x / 7) = (x * Recip7W) >> Recip7WSh for x < 2^15
  localparam logic [15:0] Recip7W = 16'd37450;
  localparam int Recip7WSh = 18;

  // floor(x / 7) = (x * Recip7N) >> Recip7NSh for x < 2^9
  localparam logic [9:0] Recip7N = 10'd586;
  localparam int Recip7NSh = 12;

  localparam logic [2:0] NegBaseDow = 3'd5;  // weekday offset of year -1
  localparam logic [9:0] DaysLastWk = 10'd364;

endpackage
`default_nettype wire

[src/iso_week_date_calculator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iso_week_date_calculator
// gregorian date to iso weekday, day of year and iso 8601 week number
// ----------------------------------------------------------------------------
// channel   direction  handshake           fields
// command   in         start_i / busy_o    year_i, month_i, day_i
// result    out        done_o (strobe)     weekday_o, day_of_year_o, iso_week_o
//
// eight register stages, one item accepted every cycle, busy_o stays low
// a result appears on done_o once its item has passed stages a..g and the output register
// the four reciprocal multiplies (by 100, by 7 three times) set the stage cut
// reset clears only the valid bits, payload registers are not reset
// the receiver cannot stall, so items are never held inside the pipe
// ----------------------------------------------------------------------------
module iso_week_date_calculator
  import iwd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [YearW-1:0]    year_i,
  input  wire logic [MonthW-1:0]   month_i,
  input  wire logic [DayW-1:0]     day_i,
  output logic                     done_o,
  output logic [WeekdayW-1:0]      weekday_o,
  output logic [DoyW-1:0]          day_of_year_o,
  output logic [WeekW-1:0]         iso_week_o
);

`include "iso_week_date_calculator_defines.svh"

  localparam int Latency = 8;
  localparam int Stages = 7;  // internal stages before the output register

  // valid bits, one per internal stage a..g
  logic [Stages-1:0] vld_q, vld_d;
  logic              done_q;

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;  // fully pipelined, always ready

  // ---------------- stage a: base year, first reciprocal multiply ----------
  logic              early;
  logic              base_neg;
  logic [YearW-1:0]  ubase;
  logic signed [OrdW-1:0] ord_pre;

  assign early    = month_i < MonthW'(3);
  // year 0 in jan/feb gives base year -1, handled as a special case
  assign base_neg = early && (year_i == '0);
  assign ubase    = early ? (year_i - YearW'(1)) : year_i;
  assign ord_pre  = $signed({{(OrdW-DayW){1'b0}}, day_i}) + OrdOffset[month_i];

  logic [YearW-1:0]   ubase_a_q;
  logic               base_neg_a_q;
  logic               late_a_q;
  logic [27:0]        p100_a_q;
  logic signed [OrdW-1:0] ord_a_q;

  // ---------------- stage b: leap count and leap flag ----------------------
  logic [7:0]  q100;
  logic [14:0] q100x;
  logic [YearW-1:0] r100;
  logic [YearW-1:0] lb;
  logic        leap_b;

  assign q100  = p100_a_q[Recip100Sh +: 8];
  assign q100x = q100 * Hundred;
  assign r100  = ubase_a_q - q100x[YearW-1:0];
  // floor(b/4) - floor(b/100) + floor(b/400), b >= 0 here
  assign lb    = {2'b00, ubase_a_q[YearW-1:2]} - {6'd0, q100} + {8'd0, q100[7:2]};
  assign leap_b = !base_neg_a_q && (ubase_a_q[1:0] == 2'b00) &&
                  ((r100 != '0) || (q100[1:0] == 2'b00));

  logic [14:0]  s_b_q;
  logic         leap_b_q, base_neg_b_q, late_b_q;
  logic signed [OrdW-1:0] ord_b_q;

  // ---------------- stage c: ordinal day, mod 7 multiply -------------------
  logic signed [OrdW-1:0] ord_c;
  assign ord_c = ord_b_q + (late_b_q ? $signed({{(OrdW-1){1'b0}}, leap_b_q}) : '0);

  logic [30:0]  p7_c_q;
  logic [14:0]  s_c_q;
  logic [1:0]   corr_c_q;
  logic         leap_c_q, base_neg_c_q;
  logic signed [OrdW-1:0] ord_c_q;

  // ---------------- stage d: year weekday offset g -------------------------
  logic [11:0] q7w;
  logic [14:0] rem7w;
  logic [2:0]  g_d;
  logic signed [10:0] x_d;

  assign q7w   = p7_c_q[Recip7WSh +: 12];
  assign rem7w = s_c_q - ({q7w, 3'b000} - {3'b000, q7w});
  assign g_d   = base_neg_c_q ? NegBaseDow : rem7w[2:0];
  // weekday argument, biased by 35 so it is never negative
  assign x_d   = 11'(ord_c_q) + $signed({8'd0, g_d}) - $signed({9'd0, corr_c_q}) + 11'sd35;

  logic [8:0]  x_d_q;
  logic [2:0]  g_d_q;
  logic        leap_d_q;
  logic signed [OrdW-1:0] ord_d_q;

  // ---------------- stage e: weekday multiply ------------------------------
  logic [18:0] px_e_q;
  logic [8:0]  x_e_q;
  logic [2:0]  g_e_q;
  logic        leap_e_q;
  logic signed [OrdW-1:0] ord_e_q;

  // ---------------- stage f: weekday and week anchor -----------------------
  logic [6:0]  qx;
  logic [8:0]  remx;
  logic [2:0]  wd_f;
  logic signed [10:0] n_f;

  assign qx   = px_e_q[Recip7NSh +: 7];
  assign remx = x_e_q - ({2'b00, qx} * 9'd7);
  assign wd_f = remx[2:0];
  assign n_f  = 11'(ord_e_q) + 11'sd3 - $signed({8'd0, wd_f});

  logic signed [10:0] n_f_q;
  logic [2:0]  wd_f_q, g_f_q;
  logic        leap_f_q;
  logic [DoyW-1:0] doy_f_q;

  // ---------------- stage g: week multiply ---------------------------------
  logic [18:0] pn_g_q;
  logic signed [10:0] n_g_q;
  logic [2:0]  wd_g_q, g_g_q;
  logic        leap_g_q;
  logic [DoyW-1:0] doy_g_q;

  // ---------------- output: week select ------------------------------------
  logic [WeekW-1:0] week_h;
  logic             n_neg, n_over;

  assign n_neg  = n_g_q[10];
  assign n_over = !n_neg && (n_g_q[9:0] > (DaysLastWk + {9'd0, leap_g_q}));

  always_comb begin
    priority if (n_neg) begin
      // week 52 or 53 of the prior year
      week_h = ({1'b0, g_g_q} >= (4'd5 + {3'd0, leap_g_q})) ? WeekW'(52) : WeekW'(53);
    end else if (n_over) begin
      week_h = WeekW'(1);
    end else begin
      week_h = pn_g_q[Recip7NSh +: WeekW] + WeekW'(1);
    end
  end

  // ---------------- valid chain ---------------------------------------------
  assign vld_d = {vld_q[Stages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[Stages-1];
    end
  end

  // ---------------- payload registers ---------------------------------------
  always_ff @(posedge clk_i) begin
    // a
    ubase_a_q    <= ubase;
    base_neg_a_q <= base_neg;
    late_a_q     <= !early;
    p100_a_q     <= ubase * Recip100;
    ord_a_q      <= ord_pre;
    // b
    s_b_q        <= {1'b0, ubase_a_q} + {1'b0, lb};
    leap_b_q     <= leap_b;
    base_neg_b_q <= base_neg_a_q;
    late_b_q     <= late_a_q;
    ord_b_q      <= ord_a_q;
    // c
    p7_c_q       <= s_b_q * Recip7W;
    s_c_q        <= s_b_q;
    corr_c_q     <= late_b_q ? (2'd1 + {1'b0, leap_b_q}) : 2'd0;
    leap_c_q     <= leap_b_q;
    base_neg_c_q <= base_neg_b_q;
    ord_c_q      <= ord_c;
    // d
    x_d_q        <= x_d[8:0];
    g_d_q        <= g_d;
    leap_d_q     <= leap_c_q;
    ord_d_q      <= ord_c_q;
    // e
    px_e_q       <= x_d_q * Recip7N;
    x_e_q        <= x_d_q;
    g_e_q        <= g_d_q;
    leap_e_q     <= leap_d_q;
    ord_e_q      <= ord_d_q;
    // f
    n_f_q        <= n_f;
    wd_f_q       <= wd_f;
    g_f_q        <= g_e_q;
    leap_f_q     <= leap_e_q;
    doy_f_q      <= ord_e_q[DoyW-1:0] + DoyW'(1);
    // g
    pn_g_q       <= n_f_q[8:0] * Recip7N;
    n_g_q        <= n_f_q;
    wd_g_q       <= wd_f_q;
    g_g_q        <= g_f_q;
    leap_g_q     <= leap_f_q;
    doy_g_q      <= doy_f_q;
    // output
    weekday_o     <= wd_g_q + WeekdayW'(1);
    day_of_year_o <= doy_g_q;
    iso_week_o    <= week_h;
  end

  assign done_o = done_q;

  // ---------------- assertions ----------------------------------------------
  `IWD_ASSERT_LATER(a_item_to_result, accept, Latency, done_o)
  `IWD_ASSERT_NOW(a_result_from_item, done_o, $past(accept, Latency))
  `IWD_ASSERT_NOW(a_weekday_range, done_o, weekday_o != '0)
  `IWD_ASSERT_NOW(a_week_range, done_o, (iso_week_o != '0) && (iso_week_o <= WeekW'(53)))

endmodule
`default_nettype wire

[tb/tb_iso_week_date_calculator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_iso_week_date_calculator
// self-checking bench: directed dates, then random dates against a predictor
// ----------------------------------------------------------------------------
// a directed table opens the run: the extremes of the year range, the week
// wrap at both ends of the year, leap days and out-of-range field values;
// a few rows carry their answer typed in, the rest go through the predictor
// then about 1400 random dates follow, mostly valid and weighted toward the
// first and last days of the year, with some raw field noise mixed in
// results are checked in order against a queue of pending week dates
// ----------------------------------------------------------------------------
module tb_iso_week_date_calculator;
  import iwd_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int ResetCycles = 12;
  localparam int Latency = 8;
  localparam int NumDirected = 24;
  localparam int NumRandom = 1426;
  localparam int unsigned CycleLimit = 400000;

  // one result item, laid out as on the result ports
  typedef struct packed {
    logic [WeekdayW-1:0] weekday;
    logic [DoyW-1:0]     doy;
    logic [WeekW-1:0]    week;
  } week_date_t;

  // one date to send, with an optional answer typed in by hand
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              typed;
    week_date_t        answer;
  } date_row_t;

  // directed dates; typed answers are calendar facts that are easy to check
  localparam date_row_t DirectedRows [NumDirected] = '{
    '{14'd1,     4'd1,  5'd1,  1'b1, '{3'd1, 9'd1,   6'd1}},   // first day of year 1
    '{14'd0,     4'd1,  5'd1,  1'b1, '{3'd6, 9'd1,   6'd52}},  // year 0, base year -1
    '{14'd9999,  4'd12, 5'd31, 1'b1, '{3'd5, 9'd365, 6'd52}},  // last day in range
    '{14'd2021,  4'd1,  5'd1,  1'b1, '{3'd5, 9'd1,   6'd53}},  // prior-year week 53
    '{14'd2021,  4'd1,  5'd3,  1'b1, '{3'd7, 9'd3,   6'd53}},
    '{14'd2020,  4'd12, 5'd31, 1'b1, '{3'd4, 9'd366, 6'd53}},  // leap year, week 53
    '{14'd2019,  4'd12, 5'd30, 1'b1, '{3'd1, 9'd364, 6'd1}},   // wraps to next week 1
    '{14'd2024,  4'd1,  5'd1,  1'b1, '{3'd1, 9'd1,   6'd1}},
    '{14'd2000,  4'd2,  5'd29, 1'b1, '{3'd2, 9'd60,  6'd9}},   // leap day, 400 rule
    '{14'd1900,  4'd2,  5'd28, 1'b0, '0},                      // century, not leap
    '{14'd1900,  4'd3,  5'd1,  1'b0, '0},
    '{14'd2004,  4'd12, 5'd31, 1'b0, '0},
    '{14'd2005,  4'd1,  5'd2,  1'b0, '0},
    '{14'd2010,  4'd1,  5'd3,  1'b0, '0},
    '{14'd2022,  4'd1,  5'd1,  1'b0, '0},
    '{14'd2024,  4'd7,  5'd15, 1'b0, '0},
    '{14'd2024,  4'd2,  5'd29, 1'b0, '0},
    '{14'd400,   4'd12, 5'd31, 1'b0, '0},
    '{14'd0,     4'd0,  5'd0,  1'b0, '0},                      // month 0, day 0
    '{14'd16383, 4'd15, 5'd31, 1'b0, '0},                      // every bit set
    '{14'd12000, 4'd13, 5'd0,  1'b0, '0},                      // past the month range
    '{14'd2023,  4'd14, 5'd5,  1'b0, '0},
    '{14'd1,     4'd2,  5'd31, 1'b0, '0},                      // day past month end
    '{14'd2025,  4'd11, 5'd30, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [YearW-1:0] year_i;
  logic [MonthW-1:0] month_i;
  logic [DayW-1:0] day_i;
  logic done_o;
  logic [WeekdayW-1:0] weekday_o;
  logic [DoyW-1:0] day_of_year_o;
  logic [WeekW-1:0] iso_week_o;

  // typed answer that travels with the item on the ports
  logic typed_answer_valid;
  week_date_t typed_answer;

  week_date_t pending_week_dates [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  iso_week_date_calculator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .done_o        (done_o),
    .weekday_o     (weekday_o),
    .day_of_year_o (day_of_year_o),
    .iso_week_o    (iso_week_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // quotient rounded toward minus infinity
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  // gregorian leap years from year 1 through y; the difference flags year 0 as leap
  function automatic longint leap_years_through(input longint y);
    return floor_quot(y, 4) - floor_quot(y, 100) + floor_quot(y, 400);
  endfunction

  function automatic longint wrap7(input longint a);
    longint r;
    r = a % 7;
    if (r < 0) r = r + 7;
    return r;
  endfunction

  // jan and feb take the year before as the base year; ord counts from jan 1
  function automatic week_date_t predict_week_date(input logic [YearW-1:0] year,
                                                   input logic [MonthW-1:0] month,
                                                   input logic [DayW-1:0] day);
    longint base, leaps, leap, corr, ord, base_dow, dow, n, week, doy, weekday;
    week_date_t r;
    base = (month < 3) ? longint'(year) - 1 : longint'(year);
    leaps = leap_years_through(base);
    leap = leaps - leap_years_through(base - 1);
    if (month < 3) begin
      corr = 0;
      ord = longint'(day) - 1 + 31 * (longint'(month) - 1);
    end else begin
      corr = leap + 1;
      ord = longint'(day) + (153 * (longint'(month) - 3) + 2) / 5 + 58 + leap;
    end
    base_dow = wrap7(base + leaps);
    dow = wrap7(ord + base_dow - corr);
    n = ord + 3 - dow;
    // early january falls back to the last week of the prior year, with a
    // quotient that truncates toward zero; late december can wrap to week 1
    if (n < 0) week = 53 - (base_dow - leap) / 5;
    else if (n > 364 + leap) week = 1;
    else week = n / 7 + 1;
    weekday = dow + 1;
    doy = ord + 1;
    r.weekday = weekday[WeekdayW-1:0];
    r.doy = doy[DoyW-1:0];
    r.week = week[WeekW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: queue an answer per accepted item, check each done strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    week_date_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (typed_answer_valid) pending_week_dates.push_back(typed_answer);
        else pending_week_dates.push_back(predict_week_date(year_i, month_i, day_i));
      end
      if (done_o) begin
        if (pending_week_dates.size() == 0) begin
          $display("%0t: result with no date pending: weekday %0d doy %0d week %0d",
                   $time, weekday_o, day_of_year_o, iso_week_o);
          mismatches++;
        end else begin
          want = pending_week_dates.pop_front();
          if (weekday_o !== want.weekday) begin
            $display("%0t: weekday expected %0d got %0d", $time, want.weekday, weekday_o);
            mismatches++;
          end
          if (day_of_year_o !== want.doy) begin
            $display("%0t: day of year expected %0d got %0d", $time, want.doy,
                     day_of_year_o);
            mismatches++;
          end
          if (iso_week_o !== want.week) begin
            $display("%0t: iso week expected %0d got %0d", $time, want.week, iso_week_o);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, pending_week_dates.size());
      $display("tb_iso_week_date_calculator: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // hold start low, with junk on the date fields that must be ignored
  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      repeat (cycles) begin
        year_i <= YearW'($urandom);
        month_i <= MonthW'($urandom);
        day_i <= DayW'($urandom);
        @(posedge clk_i);
      end
    end
  endtask

  // present one date and return at the edge that takes it
  task automatic send_date(input date_row_t row);
    start_i <= 1'b1;
    year_i <= row.year;
    month_i <= row.month;
    day_i <= row.day;
    typed_answer_valid <= row.typed;
    typed_answer <= row.answer;
    do @(posedge clk_i); while (busy_o);
  endtask

  // stop sending until every pending result has come back
  task automatic drain_pending();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_week_dates.size() != 0);
  endtask

  initial begin
    date_row_t row;
    int unsigned pick;
    int unsigned month_days;
    bit leap_year;
    bit steady;

    rst_ni = 1'b0;
    start_i = 1'b0;
    year_i = '0;
    month_i = '0;
    day_i = '0;
    typed_answer_valid = 1'b0;
    typed_answer = '0;
    steady = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    for (int i = 0; i < NumDirected; i++) begin
      idle_for(pick_gap(i < 8));
      send_date(DirectedRows[i]);
    end
    drain_pending();

    // random dates, in blocks that are either steady or gappy
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(3, 0) == 0);
      if (i == NumRandom / 2) drain_pending();
      row = '0;
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        // raw noise over every field value, including invalid dates
        row.year = YearW'($urandom_range(16383, 0));
        row.month = MonthW'($urandom_range(15, 0));
        row.day = DayW'($urandom_range(31, 0));
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 80) row.year = YearW'($urandom_range(9999, 1));
        else if (pick < 90) row.year = YearW'($urandom_range(3, 0));
        else row.year = YearW'($urandom_range(16383, 10000));
        leap_year = (row.year % 4 == 0 && row.year % 100 != 0) || row.year % 400 == 0;
        pick = $urandom_range(99, 0);
        if (pick < 20) begin
          // first week of january, where the week may belong to the prior year
          row.month = MonthW'(1);
          row.day = DayW'($urandom_range(7, 1));
        end else if (pick < 40) begin
          // last days of december, where week 1 of the next year can start
          row.month = MonthW'(12);
          row.day = DayW'($urandom_range(31, 22));
        end else begin
          row.month = MonthW'($urandom_range(12, 1));
          case (row.month)
            4, 6, 9, 11: month_days = 30;
            2: month_days = leap_year ? 29 : 28;
            default: month_days = 31;
          endcase
          row.day = DayW'($urandom_range(month_days, 1));
        end
      end
      idle_for(pick_gap(steady));
      send_date(row);
    end

    // let the pipe empty, then watch a while for stray strobes
    drain_pending();
    repeat (2 * Latency) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_iso_week_date_calculator: done, clean");
    end else begin
      $display("tb_iso_week_date_calculator: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
